// ===== sv/fpw_pkg.sv =====
// ----------------------------------------------------------------------------
// fpw_pkg
// Shared types, constants and helpers for the framebuffer pixel format writer.
// ----------------------------------------------------------------------------
package fpw_pkg;

  localparam int MAX_LINE_PIXELS = 4096;
  localparam int MAX_LINES       = 4096;
  localparam int OFFSET_BITS     = 28;

  localparam int FMT_W    = 3;
  localparam int LP_W     = 13;
  localparam int PAD_W    = 12;
  localparam int FL_W     = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W    = 32;
  localparam int BYTES_W  = 3;

  localparam int COL_W = $clog2(MAX_LINE_PIXELS);
  localparam int ROW_W = $clog2(MAX_LINES);
  localparam int LCMP_W = (COL_W + 1 > LP_W) ? COL_W + 1 : LP_W;
  localparam int RCMP_W = (ROW_W + 1 > FL_W) ? ROW_W + 1 : FL_W;

  typedef enum logic [FMT_W-1:0] {
    FMT_XRGB32 = 3'd0,
    FMT_BGR24  = 3'd1,
    FMT_RGB565 = 3'd2,
    FMT_RGB555 = 3'd3,
    FMT_RGB332 = 3'd4
  } fmt_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PIXELS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PADDING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LINES  = 2'd3;

  localparam logic [LP_W-1:0] LP_RESET = 13'd1024;
  localparam logic [FL_W-1:0] FL_RESET = 13'd768;

  typedef struct packed {
    logic [FMT_W-1:0] pixel_format;
    logic [LP_W-1:0]  line_pixels;
    logic [PAD_W-1:0] line_padding;
    logic [FL_W-1:0]  frame_lines;
  } cfg_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] byte_offset;
    logic                   line_end;
    logic                   frame_end;
  } pos_t;

  // zero reads as one, oversize saturates
  function automatic logic [LP_W-1:0] clamp_count(input logic [LP_W-1:0] v, input int maxv);
    logic [LP_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LP_W'(1);
    end else if (int'(v) > maxv) begin
      r = LP_W'(maxv);
    end
    return r;
  endfunction

endpackage

// ===== sv/fpw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fpw_cfg_regs
// Configuration register file; line and frame sizes are stored clamped.
// ----------------------------------------------------------------------------
module fpw_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [fpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpw_pkg::CFG_W-1:0]     cfg_data,
  output fpw_pkg::cfg_t                 cfg
);
  import fpw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT: cfg_nxt.pixel_format = cfg_data[FMT_W-1:0];
        CFG_LINE_PIXELS:  cfg_nxt.line_pixels  = clamp_count(cfg_data[LP_W-1:0], MAX_LINE_PIXELS);
        CFG_LINE_PADDING: cfg_nxt.line_padding = cfg_data[PAD_W-1:0];
        CFG_FRAME_LINES:  cfg_nxt.frame_lines  = clamp_count(cfg_data[FL_W-1:0], MAX_LINES);
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format <= FMT_XRGB32;
      cfg_r.line_pixels  <= clamp_count(LP_RESET, MAX_LINE_PIXELS);
      cfg_r.line_padding <= '0;
      cfg_r.frame_lines  <= clamp_count(FL_RESET, MAX_LINES);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/fpw_convert.sv =====
// ----------------------------------------------------------------------------
// fpw_convert
// XRGB8888 to selected framebuffer format, with byte count.
// ----------------------------------------------------------------------------
module fpw_convert (
  input  logic [fpw_pkg::FMT_W-1:0]   pixel_format,
  input  logic [fpw_pkg::PIX_W-1:0]   pixel,
  output logic [fpw_pkg::PIX_W-1:0]   write_data,
  output logic [fpw_pkg::BYTES_W-1:0] byte_count
);
  import fpw_pkg::*;

  always_comb begin
    case (pixel_format)
      FMT_BGR24: begin
        write_data = {8'd0, pixel[23:0]};
        byte_count = 3'd3;
      end
      FMT_RGB565: begin
        write_data = {16'd0, pixel[23:19], pixel[15:10], pixel[7:3]};
        byte_count = 3'd2;
      end
      FMT_RGB555: begin
        write_data = {17'd0, pixel[23:19], pixel[15:11], pixel[7:3]};
        byte_count = 3'd2;
      end
      FMT_RGB332: begin
        write_data = {24'd0, pixel[23:21], pixel[15:13], pixel[7:6]};
        byte_count = 3'd1;
      end
      default: begin
        write_data = pixel;
        byte_count = 3'd4;
      end
    endcase
  end

endmodule

// ===== sv/fpw_addr_gen.sv =====
// ----------------------------------------------------------------------------
// fpw_addr_gen
// Column, row and byte offset counters with line padding and frame wrap.
// ----------------------------------------------------------------------------
module fpw_addr_gen (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fpw_pkg::cfg_t               cfg,
  input  logic                        advance,
  input  logic [fpw_pkg::BYTES_W-1:0] byte_count,
  output fpw_pkg::pos_t               pos
);
  import fpw_pkg::*;

  logic [COL_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [OFFSET_BITS-1:0] ofs_r, ofs_nxt;
  logic                   lend;
  logic                   fend;

  assign lend = (LCMP_W'(col_r) + LCMP_W'(1)) >= LCMP_W'(cfg.line_pixels);
  assign fend = lend && ((RCMP_W'(row_r) + RCMP_W'(1)) >= RCMP_W'(cfg.frame_lines));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ofs_nxt = ofs_r;
    if (advance) begin
      if (fend) begin
        col_nxt = '0;
        row_nxt = '0;
        ofs_nxt = '0;
      end else if (lend) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
        ofs_nxt = ofs_r + OFFSET_BITS'(byte_count) + OFFSET_BITS'(cfg.line_padding);
      end else begin
        col_nxt = col_r + COL_W'(1);
        ofs_nxt = ofs_r + OFFSET_BITS'(byte_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ofs_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ofs_r <= ofs_nxt;
    end
  end

  assign pos.byte_offset = ofs_r;
  assign pos.line_end    = lend;
  assign pos.frame_end   = fend;

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && fend) |=> (ofs_r == '0 && col_r == '0 && row_r == '0))
    else $error("counters did not wrap after frame end");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !lend) |=> (col_r == $past(col_r) + COL_W'(1) && row_r == $past(row_r)))
    else $error("column did not step inside line");

  a_line_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && lend && !fend) |=> (col_r == '0 && row_r == $past(row_r) + ROW_W'(1)))
    else $error("row did not step at line end");

endmodule

// ===== sv/framebuffer_pixel_format_writer.sv =====
// ----------------------------------------------------------------------------
// framebuffer_pixel_format_writer
// Converts XRGB8888 pixels into framebuffer writes with offset tracking.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, from input transaction to
//   result valid.
// Throughput: one pixel per cycle while out_stall is low; the counters step per pixel.
// Reset (rst_n low, synchronous): pipeline empties, counters clear, config
//   returns to 32bpp, 1024 pixels per line, no padding, 768 lines.
module framebuffer_pixel_format_writer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpw_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fpw_pkg::PIX_W-1:0]       in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fpw_pkg::OFFSET_BITS-1:0] out_byte_offset,
  output logic [fpw_pkg::PIX_W-1:0]       out_write_data,
  output logic [fpw_pkg::BYTES_W-1:0]     out_byte_count,
  output logic                            out_line_end,
  output logic                            out_frame_end
);
  import fpw_pkg::*;

  cfg_t                 cfg;
  pos_t                 pos;
  logic                 s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]     s1_pixel_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [OFFSET_BITS-1:0] ofs_r;
  logic [PIX_W-1:0]     data_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic                 lend_r;
  logic                 fend_r;
  logic [PIX_W-1:0]     conv_data;
  logic [BYTES_W-1:0]   conv_bytes;
  logic                 out_load;
  logic                 s1_move;
  logic                 in_take;

  fpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpw_convert u_conv (
    .pixel_format (cfg.pixel_format),
    .pixel        (s1_pixel_r),
    .write_data   (conv_data),
    .byte_count   (conv_bytes)
  );

  fpw_addr_gen u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .advance    (s1_move),
    .byte_count (conv_bytes),
    .pos        (pos)
  );

  assign out_load = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel_r <= in_pixel;
    end
    if (s1_move) begin
      ofs_r   <= pos.byte_offset;
      data_r  <= conv_data;
      bytes_r <= conv_bytes;
      lend_r  <= pos.line_end;
      fend_r  <= pos.frame_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_offset = ofs_r;
  assign out_write_data  = data_r;
  assign out_byte_count  = bytes_r;
  assign out_line_end    = lend_r;
  assign out_frame_end   = fend_r;

endmodule
